[src/sis_pkg.sv]
// Shared types and constants of the sorted integer set.
package sis_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  // Request codes. The fourth code behaves as a lookup.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Command broadcast to every cell of the chain during the update cycle.
  typedef struct packed {
    logic shift_up;    // make room: cells at and above the insert point move up
    logic shift_down;  // close a gap: cells at and above the hit take the next value
  } sis_cell_cmd_t;

endpackage

[src/sis_if.sv]
// Request and result channel interfaces of the sorted integer set.
interface sis_in_if;
  import sis_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sis_out_if;
  import sis_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  count;
  logic                full_reject;

  modport source (output valid, output found, output position, output count,
                  output full_reject, input ready);
  modport sink   (input valid, input found, input position, input count,
                  input full_reject, output ready);
endinterface

[src/sis_cell.sv]
// One storage cell of the sorted chain: holds a value and its compare flags.
module sis_cell
  import sis_pkg::*;
(
  input  logic                       clk,
  input  logic                       occupied,
  input  logic                       cmp_en,
  input  logic signed [VALUE_W-1:0]  cmp_value,
  input  logic                       less_prev,
  input  logic signed [VALUE_W-1:0]  value_prev,
  input  logic signed [VALUE_W-1:0]  value_next,
  input  logic signed [VALUE_W-1:0]  ins_value,
  input  sis_cell_cmd_t              cmd,
  output logic signed [VALUE_W-1:0]  value,
  output logic                       less,
  output logic                       eq
);

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      less_r;
  logic                      eq_r;

  // A cell whose stored value is not below the request value sits at or
  // above the insert point, so it is the one that moves.
  always_comb begin
    value_nxt = value_r;
    if (cmd.shift_up && !less_r) begin
      value_nxt = less_prev ? ins_value : value_prev;
    end else if (cmd.shift_down && !less_r) begin
      value_nxt = value_next;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (cmp_en) begin
      less_r <= occupied && (value_r < cmp_value);
      eq_r   <= occupied && (value_r == cmp_value);
    end
  end

  assign value = value_r;
  assign less  = less_r;
  assign eq    = eq_r;

endmodule

[src/sorted_integer_set.sv]
// Top level of the sorted integer set: cell chain, count and result register.
//
// The block keeps up to CAPACITY distinct signed 32-bit integers in ascending
// order in a chain of cells, one value per cell, and serves one request per
// beat: lookup, add or remove. In the cycle a request is accepted, every
// occupied cell compares its value with the request value in parallel and
// records "below" and "equal"; in the update cycle, which comes once the
// output register can take the result, the hit is encoded into a position,
// the count is updated and, for an add of a new value or a remove of a
// present one, every cell at or above the insert point takes its neighbour's
// value in a single step. The update writes the result beat into the output
// register; no new request is taken until the update is done. A finished
// result may wait on the output while the next request is accepted and
// compared; the update of that request waits until the output register is
// free. An add to a full set that is not already present leaves the set
// alone and reports full_reject. Position is reported modulo 64 and count
// modulo 128 when CAPACITY is larger than those fields can hold. No clearing
// pass is needed after reset: cells at or above the count are never treated
// as holding a value.
module sorted_integer_set
  import sis_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sis_in_if.sink      in_chan,
  sis_out_if.source   out_chan
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_X = IDX_W + POS_W;
  localparam int unsigned CNT_X = CNT_W + COUNT_W;

  // Request held between the compare cycle and the update cycle.
  logic                       busy_r;
  logic [OP_W-1:0]            op_r;
  logic signed [VALUE_W-1:0]  value_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;

  // Output register.
  logic                       out_valid_r;
  logic                       found_r;
  logic [POS_W-1:0]           position_r;
  logic [COUNT_W-1:0]         count_out_r;
  logic                       full_reject_r;

  logic                       in_beat;
  logic                       exec;
  logic                       found;
  logic                       is_full;
  logic                       do_add;
  logic                       do_remove;
  logic                       reject;
  sis_cell_cmd_t              cmd;
  logic [IDX_W-1:0]           pos_enc;
  logic [POS_X-1:0]           pos_ext;
  logic [CNT_X-1:0]           cnt_ext;

  logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
  logic                       cell_less  [CAPACITY];
  logic                       cell_eq    [CAPACITY];

  assign in_chan.ready = !busy_r;
  assign in_beat       = in_chan.valid && !busy_r;

  // The update runs once the output register can take the result.
  assign exec = busy_r && (!out_valid_r || out_chan.ready);

  // Values are distinct, so at most one cell reports equal; its index is the
  // position, and with no hit the encoded index is zero.
  always_comb begin
    found   = 1'b0;
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | cell_eq[i];
      if (cell_eq[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
  end

  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign do_add    = exec && (op_r == OP_ADD) && !found && !is_full;
  assign reject    = (op_r == OP_ADD) && !found && is_full;
  assign do_remove = exec && (op_r == OP_REMOVE) && found;

  assign cmd.shift_up   = do_add;
  assign cmd.shift_down = do_remove;

  always_comb begin
    count_nxt = count_r;
    if (do_add) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign pos_ext = POS_X'(pos_enc);
  assign cnt_ext = CNT_X'(count_nxt);

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                      less_prev;
      logic signed [VALUE_W-1:0] value_prev;
      logic signed [VALUE_W-1:0] value_next;

      // The bottom cell always sees a "below" neighbour, so an insert at the
      // front loads the new value there; the top cell has nothing above it.
      if (g == 0) begin : g_first
        assign less_prev  = 1'b1;
        assign value_prev = value_r;
      end else begin : g_mid
        assign less_prev  = cell_less[g-1];
        assign value_prev = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign value_next = cell_value[g];
      end else begin : g_inner
        assign value_next = cell_value[g+1];
      end

      sis_cell u_cell (
        .clk        (clk),
        .occupied   (CNT_W'(g) < count_r),
        .cmp_en     (in_beat),
        .cmp_value  (in_chan.value),
        .less_prev  (less_prev),
        .value_prev (value_prev),
        .value_next (value_next),
        .ins_value  (value_r),
        .cmd        (cmd),
        .value      (cell_value[g]),
        .less       (cell_less[g]),
        .eq         (cell_eq[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        busy_r  <= 1'b1;
        op_r    <= in_chan.op;
        value_r <= in_chan.value;
      end else if (exec) begin
        busy_r <= 1'b0;
      end

      count_r <= count_nxt;

      if (exec) begin
        out_valid_r   <= 1'b1;
        found_r       <= found;
        position_r    <= pos_ext[POS_W-1:0];
        count_out_r   <= cnt_ext[COUNT_W-1:0];
        full_reject_r <= reject;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = found_r;
  assign out_chan.position    = position_r;
  assign out_chan.count       = count_out_r;
  assign out_chan.full_reject = full_reject_r;

endmodule

[src/sis_checker.sv]
// Port-level checker for the sorted integer set and its bind.
module sis_checker
  import sis_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               found,
  input logic [POS_W-1:0]   position,
  input logic               full_reject
);

  // Reset empties the result register.
  a_reset_clears_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result beat is not withdrawn.
  a_out_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A refused add only happens for a value not already stored.
  a_reject_not_found : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && full_reject |-> !found)
    else $error("full_reject together with found");

  // A miss carries no position.
  a_miss_pos_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> position == '0)
    else $error("position non-zero on a miss");

endmodule

bind sorted_integer_set sis_checker u_sis_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .found       (out_chan.found),
  .position    (out_chan.position),
  .full_reject (out_chan.full_reject)
);

[tb/sv/tb_sorted_integer_set.sv]
// Self-checking testbench of the sorted integer set: directed table, then random rounds.
`timescale 1ns / 1ps

module tb_sorted_integer_set;
  import sis_pkg::*;

  // The block takes no new request while one is in progress and registers
  // its result, so a short pause covers anything in flight.
  localparam int unsigned SET_CAP     = 64;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned ROUNDS      = 4;
  localparam int unsigned FILL_ITEMS  = 170;
  localparam int unsigned DRAIN_ITEMS = 150;

  // Lookup has no name in the package; the spare fourth code acts as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               full_reject;
  } set_result_t;

  // One row of the directed table. Where has_lit is set, the expected result
  // is typed in by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [OP_W-1:0] op;
    value_t          value;
    logic            has_lit;
    set_result_t     lit;
  } stim_row_t;

  typedef enum {RX_FLOW, RX_COIN, RX_TRICKLE, RX_HICCUP} rx_mode_t;
  typedef enum {ROUND_FILL, ROUND_DRAIN} round_kind_t;

  localparam int unsigned DIRECTED_N = 25;

  // Empty-set behaviour and the two extremes are obvious by inspection; the
  // rest walks through present and absent adds, the spare code, removal at
  // the bottom, the top and the middle, and emptying the set again.
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{OP_LOOKUP, 32'sd0,          1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{OP_REMOVE, 32'sd5,          1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{OP_SPARE,  -32'sd1,         1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{OP_ADD,    VAL_MIN,         1'b1, '{1'b0, 6'd0, 7'd1, 1'b0}},
    '{OP_ADD,    VAL_MAX,         1'b1, '{1'b0, 6'd0, 7'd2, 1'b0}},
    '{OP_ADD,    32'sd0,          1'b0, '0},
    '{OP_ADD,    -32'sd1,         1'b0, '0},
    '{OP_ADD,    32'sd1,          1'b0, '0},
    '{OP_ADD,    VAL_MIN,         1'b0, '0},
    '{OP_LOOKUP, VAL_MAX,         1'b0, '0},
    '{OP_LOOKUP, 32'sd2,          1'b0, '0},
    '{OP_SPARE,  32'sd0,          1'b0, '0},
    '{OP_SPARE,  VAL_MAX,         1'b0, '0},
    '{OP_ADD,    32'sh5555_5555,  1'b0, '0},
    '{OP_ADD,    32'shAAAA_AAAA,  1'b0, '0},
    '{OP_REMOVE, 32'sd7,          1'b0, '0},
    '{OP_REMOVE, 32'sd0,          1'b0, '0},
    '{OP_REMOVE, VAL_MIN,         1'b0, '0},
    '{OP_REMOVE, VAL_MAX,         1'b0, '0},
    '{OP_LOOKUP, 32'sd1,          1'b0, '0},
    '{OP_REMOVE, -32'sd1,         1'b0, '0},
    '{OP_REMOVE, 32'sd1,          1'b0, '0},
    '{OP_REMOVE, 32'sh5555_5555,  1'b0, '0},
    '{OP_REMOVE, 32'shAAAA_AAAA,  1'b0, '0},
    '{OP_LOOKUP, VAL_MIN,         1'b0, '0}
  };

  logic clk;
  logic rst_n;

  sis_in_if  in_bus ();
  sis_out_if out_bus ();

  sorted_integer_set #(.CAPACITY(SET_CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // The testbench's own copy of the set, ascending, plus the queue of result
  // beats that accepted requests are owed, oldest first.
  value_t      held_values [$];
  set_result_t owed_results [$];

  // Hand-typed expectation travelling with the request currently on the bus.
  // It is written at the falling edge together with the request itself.
  logic        lit_pending;
  set_result_t lit_result;

  int unsigned mismatches;
  int unsigned n_requests;
  int unsigned n_hits;
  int unsigned n_refused;
  int unsigned peak_count;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the set copy and returns the beat it must produce.
  // The search stops at the first entry not below the value; a hit there
  // gives the position, and only an add of a new value or a remove of a
  // present one changes the set. Anything else, the spare code included,
  // behaves as a lookup.
  function automatic set_result_t apply_request(input logic [OP_W-1:0] op, input value_t v);
    int          idx;
    bit          hit;
    set_result_t res;
    idx = 0;
    while (idx < held_values.size() && held_values[idx] < v) idx++;
    hit = (idx < held_values.size()) && (held_values[idx] == v);
    res = '0;
    if (op == OP_ADD && !hit) begin
      if (held_values.size() >= SET_CAP) res.full_reject = 1'b1;
      else held_values.insert(idx, v);
    end else if (op == OP_REMOVE && hit) begin
      held_values.delete(idx);
    end
    res.found    = hit;
    res.position = hit ? idx[POS_W-1:0] : '0;
    res.count    = COUNT_W'(held_values.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("ERROR %0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  // All checking happens here on the rising edge, reading values as they
  // stood before the edge. The result side is handled before the request
  // side so that a beat can never be matched against a request accepted at
  // the very same edge.
  always @(posedge clk) begin : check_beats
    set_result_t got;
    set_result_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.found, out_bus.position, out_bus.count, out_bus.full_reject};
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with no request owed", int'(got), 0);
        end else begin
          want = owed_results.pop_front();
          if (got.found !== want.found)
            report_mismatch("found", int'(got.found), int'(want.found));
          if (got.position !== want.position)
            report_mismatch("position", int'(got.position), int'(want.position));
          if (got.count !== want.count)
            report_mismatch("count", int'(got.count), int'(want.count));
          if (got.full_reject !== want.full_reject)
            report_mismatch("full_reject", int'(got.full_reject), int'(want.full_reject));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        // The predictor always runs so that its set stays in step, even
        // where the table overrides its answer with a typed-in one.
        want = apply_request(in_bus.op, in_bus.value);
        n_requests++;
        if (want.found) n_hits++;
        if (want.full_reject) n_refused++;
        if (held_values.size() > peak_count) peak_count = held_values.size();
        if (lit_pending) want = lit_result;
        owed_results.push_back(want);
      end
    end
  end

  // Watchdog: a run in which no beat moves on either channel for too long
  // has hung, whatever the reason.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR %0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("** sorted_integer_set: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure. It switches between free flow, coin-toss stalls,
  // a trickle of one beat in six and rare single-cycle hiccups, each mode
  // held for a random stretch, independently of what the sender does.
  initial begin : result_sink
    rx_mode_t    mode;
    int unsigned left;
    int unsigned tick;
    out_bus.ready = 1'b0;
    mode = RX_FLOW;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(10, 120);
      end
      left--;
      tick++;
      case (mode)
        RX_FLOW:    out_bus.ready <= 1'b1;
        RX_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
        RX_TRICKLE: out_bus.ready <= (tick % 6 == 0);
        default:    out_bus.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Presents one request at the falling edge and holds it until the block
  // takes it. Valid is left high on return, so back-to-back requests keep it
  // up without a dip.
  task automatic send_request(input logic [OP_W-1:0] op, input value_t v,
                              input logic has_lit, input set_result_t lit);
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.value <= v;
    lit_pending = has_lit;
    lit_result  = lit;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic hold_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
  endtask

  // Waits until every owed result beat has been taken; the watchdog guards it.
  task automatic drain_results();
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Picks a request value. Most lookups and removes aim at stored values so
  // that hits are common; adds mostly bring fresh values. The rest are a
  // tight cluster around zero, the extremes, or anything at all.
  function automatic value_t pick_value(input int unsigned member_pct);
    if (held_values.size() != 0 && $urandom_range(0, 99) < member_pct)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    case ($urandom_range(0, 9))
      0:       return $signed($urandom_range(0, 8)) - 4;
      1:       return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Fill rounds push the set up to its capacity and beyond it, so that adds
  // of new values are refused and adds of values already held in a full set
  // are not. Drain rounds then empty it again through mostly hitting removes.
  function automatic logic [OP_W-1:0] pick_op(input round_kind_t kind);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (kind == ROUND_FILL) begin
      if (roll < 70) return OP_ADD;
      if (roll < 80) return OP_LOOKUP;
      if (roll < 93) return OP_REMOVE;
      return OP_SPARE;
    end
    if (roll < 75) return OP_REMOVE;
    if (roll < 85) return OP_ADD;
    if (roll < 95) return OP_LOOKUP;
    return OP_SPARE;
  endfunction

  initial begin : stimulus
    round_kind_t     kind;
    int unsigned     burst_left;
    int unsigned     items;
    logic [OP_W-1:0] op;

    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op    = OP_LOOKUP;
    in_bus.value = '0;
    lit_pending  = 1'b0;
    lit_result   = '0;
    mismatches   = 0;
    n_requests   = 0;
    n_hits       = 0;
    n_refused    = 0;
    peak_count   = 0;
    idle_cycles  = 0;
    burst_left   = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, with a short random gap now and then so that even
    // these beats meet the block in different phases of its work.
    foreach (directed_rows[r]) begin
      if ($urandom_range(0, 3) == 0) hold_sender($urandom_range(1, 3));
      send_request(directed_rows[r].op, directed_rows[r].value,
                   directed_rows[r].has_lit, directed_rows[r].lit);
    end

    // Random rounds. The sender works in bursts, mostly short with gaps
    // between them, sometimes long unbroken stretches. Between rounds it
    // stops altogether until the block has returned every owed beat.
    for (int unsigned rnd = 0; rnd < 2 * ROUNDS; rnd++) begin
      kind  = (rnd % 2 == 0) ? ROUND_FILL : ROUND_DRAIN;
      items = (kind == ROUND_FILL) ? FILL_ITEMS : DRAIN_ITEMS;
      hold_sender(1);
      drain_results();
      for (int unsigned n = 0; n < items; n++) begin
        if (burst_left == 0) begin
          hold_sender($urandom_range(1, 6));
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
        end
        burst_left--;
        op = pick_op(kind);
        send_request(op, pick_value((op == OP_ADD) ? 15 : 75), 1'b0, '0);
      end
    end

    hold_sender(1);
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);

    if (owed_results.size() != 0)
      report_mismatch("result beats never delivered", 0, owed_results.size());

    $display("Ran %0d requests through %0d fill and drain rounds under random back-pressure.",
             n_requests, 2 * ROUNDS);
    $display("Hits: %0d, refused adds: %0d, peak occupancy %0d of %0d, mismatches: %0d.",
             n_hits, n_refused, peak_count, SET_CAP, mismatches);
    if (mismatches == 0) begin
      $display("** sorted_integer_set: PASSED **");
    end else begin
      $display("** sorted_integer_set: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
src/sis_pkg.sv
src/sis_if.sv
src/sis_cell.sv
src/sorted_integer_set.sv
src/sis_checker.sv
tb/sv/tb_sorted_integer_set.sv
